/* rtl/core/btpc_pkg.sv */
// Shared constants and types for the barometric compensation pipeline.
// No dependencies; used by the top level, the divider and the checker.
`default_nettype none

package btpc_pkg;

    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_A   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_B   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_C   = 2'd3;

    localparam int RAW_W     = 20;
    localparam int TEMP_W    = 18;
    localparam int TEMP_OUT_W = 32;
    localparam int PRESS_W   = 24;

    localparam int DIV_N_W   = 64;
    localparam int DIV_D_W   = 31;

    localparam logic [23:0] FINE_OFS   = 24'd128000;
    localparam logic [20:0] PRESS_OFS  = 21'd1048576;
    localparam logic [11:0] DIV_SCALE  = 12'd3125;
    localparam logic [25:0] TEMP_ROUND = 26'd128;
    localparam logic [63:0] H_OFS      = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic              zero;
        logic              qneg;
    } div_side_t;

endpackage

`default_nettype wire

/* rtl/core/btpc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, unsigned operands.
// Depends on btpc_pkg for widths and the side payload type.
`default_nettype none

module btpc_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            adv,
    input  logic                            in_valid,
    input  logic [btpc_pkg::DIV_N_W-1:0]    in_num,
    input  logic [btpc_pkg::DIV_D_W-1:0]    in_den,
    input  btpc_pkg::div_side_t             in_side,
    output logic                            out_valid,
    output logic [btpc_pkg::DIV_N_W-1:0]    out_quo,
    output btpc_pkg::div_side_t             out_side
);
    import btpc_pkg::*;

    logic               valid_reg [DIV_N_W];
    logic [DIV_D_W-1:0] rem_reg   [DIV_N_W];
    logic [DIV_N_W-1:0] work_reg  [DIV_N_W];
    logic [DIV_D_W-1:0] den_reg   [DIV_N_W];
    div_side_t          side_reg  [DIV_N_W];

    genvar k;
    for (k = 0; k < DIV_N_W; k++) begin : g_step
        logic               v_in;
        logic [DIV_D_W-1:0] r_in;
        logic [DIV_D_W-1:0] d_in;
        logic [DIV_N_W-1:0] w_in;
        div_side_t          sd_in;
        logic [DIV_D_W:0]   trial;
        logic               fit;
        logic [DIV_D_W-1:0] rem_next;
        logic [DIV_N_W-1:0] work_next;

        if (k == 0) begin : g_first
            assign v_in  = in_valid;
            assign r_in  = '0;
            assign d_in  = in_den;
            assign w_in  = in_num;
            assign sd_in = in_side;
        end else begin : g_rest
            assign v_in  = valid_reg[k-1];
            assign r_in  = rem_reg[k-1];
            assign d_in  = den_reg[k-1];
            assign w_in  = work_reg[k-1];
            assign sd_in = side_reg[k-1];
        end

        assign trial     = {r_in, w_in[DIV_N_W-1]};
        assign fit       = trial >= {1'b0, d_in};
        assign rem_next  = fit ? DIV_D_W'(trial - {1'b0, d_in}) : trial[DIV_D_W-1:0];
        assign work_next = {w_in[DIV_N_W-2:0], fit};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k]  <= rem_next;
                work_reg[k] <= work_next;
                den_reg[k]  <= d_in;
                side_reg[k] <= sd_in;
            end
        end
    end

    assign out_valid = valid_reg[DIV_N_W-1];
    assign out_quo   = work_reg[DIV_N_W-1];
    assign out_side  = side_reg[DIV_N_W-1];

endmodule

`default_nettype wire

/* rtl/core/baro_temp_pressure_compensation_top.sv */
// Pipeline: 12 front stages, 64 divider stages, 6 back stages and an output register.
// Throughput: one beat per cycle while the skid register is empty; input stalls while it is full.
// The 64-stage bit-serial divider pipeline sets the depth.
// A skid register behind the output holds one result while the output stalls; input then waits.
// Reset (aresetn low, synchronous) clears valid bits and all calibration registers.
// Depends on btpc_pkg and btpc_div.
`default_nettype none

module baro_temp_pressure_compensation_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [btpc_pkg::RAW_W-1:0]        s_raw_temperature,
    input  logic [btpc_pkg::RAW_W-1:0]        s_raw_pressure,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [btpc_pkg::TEMP_OUT_W-1:0] m_temperature_centi,
    output logic [btpc_pkg::PRESS_W-1:0]      m_pressure_pa,
    output logic                              m_pressure_valid,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [btpc_pkg::CFG_W-1:0]        cfg_data
);
    import btpc_pkg::*;

    // calibration registers
    logic [CFG_W-1:0] cal_t_reg, cal_a_reg, cal_b_reg, cal_c_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_t_reg <= '0;
            cal_a_reg <= '0;
            cal_b_reg <= '0;
            cal_c_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TEMP_CAL: cal_t_reg <= cfg_data;
                REG_PRESS_A:  cal_a_reg <= cfg_data;
                REG_PRESS_B:  cal_b_reg <= cfg_data;
                REG_PRESS_C:  cal_c_reg <= cfg_data;
            endcase
        end
    end

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = cal_t_reg[15:0];
    assign t2 = cal_t_reg[31:16];
    assign t3 = cal_t_reg[47:32];
    assign p1 = cal_a_reg[15:0];
    assign p2 = cal_a_reg[31:16];
    assign p3 = cal_a_reg[47:32];
    assign p4 = cal_b_reg[15:0];
    assign p5 = cal_b_reg[31:16];
    assign p6 = cal_b_reg[47:32];
    assign p7 = cal_c_reg[15:0];
    assign p8 = cal_c_reg[31:16];
    assign p9 = cal_c_reg[47:32];

    logic adv;

    // ---------------- stage 1
    logic signed [17:0] s1_adiff, s1_dt_next;
    logic signed [33:0] s1_aprod;
    logic               s1_v_reg;
    logic [31:0]        s1_aprod_reg;
    logic signed [17:0] s1_dt_reg;
    logic [RAW_W-1:0]   s1_rawp_reg;

    assign s1_adiff   = $signed({1'b0, s_raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign s1_aprod   = s1_adiff * t2;
    assign s1_dt_next = $signed({2'b0, s_raw_temperature[19:4]}) - $signed({2'b0, t1});

    // ---------------- stage 2
    logic signed [35:0] s2_dd;
    logic               s2_v_reg;
    logic [31:0]        s2_dd_reg;
    logic [20:0]        s2_a_reg;
    logic [RAW_W-1:0]   s2_rawp_reg;

    assign s2_dd = s1_dt_reg * s1_dt_reg;

    // ---------------- stage 3
    logic signed [19:0] s3_ddsh;
    logic signed [35:0] s3_bprod;
    logic               s3_v_reg;
    logic [31:0]        s3_bprod_reg;
    logic [20:0]        s3_a_reg;
    logic [RAW_W-1:0]   s3_rawp_reg;

    assign s3_ddsh  = s2_dd_reg[31:12];
    assign s3_bprod = s3_ddsh * t3;

    // ---------------- stage 4
    logic [21:0]        s4_fine;
    logic               s4_v_reg;
    logic [21:0]        s4_fine_reg;
    logic [RAW_W-1:0]   s4_rawp_reg;

    assign s4_fine = {s3_a_reg[20], s3_a_reg}
                   + {{4{s3_bprod_reg[31]}}, s3_bprod_reg[31:14]};

    // ---------------- stage 5
    logic [25:0]        s5_fine5;
    logic [23:0]        s5_x;
    logic               s5_v_reg;
    logic signed [23:0] s5_x_reg;
    logic [TEMP_W-1:0]  s5_temp_reg;
    logic [RAW_W-1:0]   s5_rawp_reg;

    assign s5_fine5 = {{4{s4_fine_reg[21]}}, s4_fine_reg}
                    + {{2{s4_fine_reg[21]}}, s4_fine_reg, 2'b00} + TEMP_ROUND;
    assign s5_x     = {{2{s4_fine_reg[21]}}, s4_fine_reg} - FINE_OFS;

    // ---------------- stage 6
    logic signed [47:0] s6_xx;
    logic signed [39:0] s6_xp5, s6_xp2;
    logic               s6_v_reg;
    logic signed [47:0] s6_xx_reg;
    logic [39:0]        s6_xp5_reg, s6_xp2_reg;
    logic [TEMP_W-1:0]  s6_temp_reg;
    logic [RAW_W-1:0]   s6_rawp_reg;

    assign s6_xx  = s5_x_reg * s5_x_reg;
    assign s6_xp5 = s5_x_reg * p5;
    assign s6_xp2 = s5_x_reg * p2;

    // ---------------- stage 7
    logic signed [63:0] s7_y1, s7_x1;
    logic               s7_v_reg;
    logic [63:0]        s7_y1_reg, s7_x1_reg;
    logic [39:0]        s7_xp5_reg, s7_xp2_reg;
    logic [TEMP_W-1:0]  s7_temp_reg;
    logic [RAW_W-1:0]   s7_rawp_reg;

    assign s7_y1 = s6_xx_reg * p6;
    assign s7_x1 = s6_xx_reg * p3;

    // ---------------- stage 8
    logic [63:0]        s8_y, s8_h;
    logic               s8_v_reg;
    logic [63:0]        s8_y_reg, s8_h_reg;
    logic [TEMP_W-1:0]  s8_temp_reg;
    logic [RAW_W-1:0]   s8_rawp_reg;

    assign s8_y = s7_y1_reg + ({{24{s7_xp5_reg[39]}}, s7_xp5_reg} << 17)
                + ({{48{p4[15]}}, p4} << 35);
    assign s8_h = H_OFS + {{8{s7_x1_reg[63]}}, s7_x1_reg[63:8]}
                + ({{24{s7_xp2_reg[39]}}, s7_xp2_reg} << 12);

    // ---------------- stage 9
    logic [20:0]        s9_pd;
    logic [63:0]        s9_pn;
    logic [47:0]        s9_hl, s9_hh;
    logic               s9_v_reg;
    logic [63:0]        s9_pn_reg;
    logic [47:0]        s9_hl_reg;
    logic [31:0]        s9_hh_reg;
    logic [TEMP_W-1:0]  s9_temp_reg;

    assign s9_pd = PRESS_OFS - {1'b0, s8_rawp_reg};
    assign s9_pn = ({43'd0, s9_pd} << 31) - s8_y_reg;
    assign s9_hl = s8_h_reg[31:0] * p1;
    assign s9_hh = s8_h_reg[63:32] * p1;

    // ---------------- stage 10
    logic [63:0]        s10_prod;
    logic [43:0]        s10_nl, s10_nh;
    logic               s10_v_reg;
    logic [DIV_D_W-1:0] s10_div_reg;
    logic [43:0]        s10_nl_reg;
    logic [31:0]        s10_nh_reg;
    logic [TEMP_W-1:0]  s10_temp_reg;

    assign s10_prod = {16'd0, s9_hl_reg} + {s9_hh_reg, 32'd0};
    assign s10_nl   = s9_pn_reg[31:0] * DIV_SCALE;
    assign s10_nh   = s9_pn_reg[63:32] * DIV_SCALE;

    // ---------------- stage 11
    logic               s11_v_reg;
    logic [63:0]        s11_n_reg;
    logic [DIV_D_W-1:0] s11_dmag_reg;
    logic               s11_dneg_reg, s11_zero_reg;
    logic [TEMP_W-1:0]  s11_temp_reg;

    // ---------------- stage 12
    logic               s12_v_reg;
    logic [63:0]        s12_nmag_reg;
    logic [DIV_D_W-1:0] s12_dmag_reg;
    div_side_t          s12_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            s6_v_reg  <= 1'b0;
            s7_v_reg  <= 1'b0;
            s8_v_reg  <= 1'b0;
            s9_v_reg  <= 1'b0;
            s10_v_reg <= 1'b0;
            s11_v_reg <= 1'b0;
            s12_v_reg <= 1'b0;
        end else if (adv) begin
            s1_v_reg  <= s_valid;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            s4_v_reg  <= s3_v_reg;
            s5_v_reg  <= s4_v_reg;
            s6_v_reg  <= s5_v_reg;
            s7_v_reg  <= s6_v_reg;
            s8_v_reg  <= s7_v_reg;
            s9_v_reg  <= s8_v_reg;
            s10_v_reg <= s9_v_reg;
            s11_v_reg <= s10_v_reg;
            s12_v_reg <= s11_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_aprod_reg <= s1_aprod[31:0];
            s1_dt_reg    <= s1_dt_next;
            s1_rawp_reg  <= s_raw_pressure;

            s2_dd_reg    <= s2_dd[31:0];
            s2_a_reg     <= s1_aprod_reg[31:11];
            s2_rawp_reg  <= s1_rawp_reg;

            s3_bprod_reg <= s3_bprod[31:0];
            s3_a_reg     <= s2_a_reg;
            s3_rawp_reg  <= s2_rawp_reg;

            s4_fine_reg  <= s4_fine;
            s4_rawp_reg  <= s3_rawp_reg;

            s5_x_reg     <= s5_x;
            s5_temp_reg  <= s5_fine5[25:8];
            s5_rawp_reg  <= s4_rawp_reg;

            s6_xx_reg    <= s6_xx;
            s6_xp5_reg   <= s6_xp5;
            s6_xp2_reg   <= s6_xp2;
            s6_temp_reg  <= s5_temp_reg;
            s6_rawp_reg  <= s5_rawp_reg;

            s7_y1_reg    <= s7_y1;
            s7_x1_reg    <= s7_x1;
            s7_xp5_reg   <= s6_xp5_reg;
            s7_xp2_reg   <= s6_xp2_reg;
            s7_temp_reg  <= s6_temp_reg;
            s7_rawp_reg  <= s6_rawp_reg;

            s8_y_reg     <= s8_y;
            s8_h_reg     <= s8_h;
            s8_temp_reg  <= s7_temp_reg;
            s8_rawp_reg  <= s7_rawp_reg;

            s9_pn_reg    <= s9_pn;
            s9_hl_reg    <= s9_hl;
            s9_hh_reg    <= s9_hh[31:0];
            s9_temp_reg  <= s8_temp_reg;

            s10_div_reg  <= s10_prod[63:33];
            s10_nl_reg   <= s10_nl;
            s10_nh_reg   <= s10_nh[31:0];
            s10_temp_reg <= s9_temp_reg;

            s11_n_reg    <= {20'd0, s10_nl_reg} + {s10_nh_reg, 32'd0};
            s11_dmag_reg <= s10_div_reg[DIV_D_W-1] ? DIV_D_W'(0) - s10_div_reg
                                                   : s10_div_reg;
            s11_dneg_reg <= s10_div_reg[DIV_D_W-1];
            s11_zero_reg <= s10_div_reg == '0;
            s11_temp_reg <= s10_temp_reg;

            s12_nmag_reg      <= s11_n_reg[63] ? 64'd0 - s11_n_reg : s11_n_reg;
            s12_dmag_reg      <= s11_dmag_reg;
            s12_side_reg.temp <= s11_temp_reg;
            s12_side_reg.zero <= s11_zero_reg;
            s12_side_reg.qneg <= s11_n_reg[63] ^ s11_dneg_reg;
        end
    end

    // ---------------- divider
    logic               dv_valid;
    logic [63:0]        dv_quo;
    div_side_t          dv_side;

    btpc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s12_v_reg),
        .in_num    (s12_nmag_reg),
        .in_den    (s12_dmag_reg),
        .in_side   (s12_side_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_side)
    );

    // ---------------- back stages
    logic              q1_v_reg, q2_v_reg, q3_v_reg, q4_v_reg, q5_v_reg, q6_v_reg;
    logic [63:0]       q1_q_reg;
    logic [TEMP_W-1:0] q1_temp_reg, q2_temp_reg, q3_temp_reg, q4_temp_reg;
    logic [TEMP_W-1:0] q5_temp_reg, q6_temp_reg;
    logic              q1_zero_reg, q2_zero_reg, q3_zero_reg, q4_zero_reg;
    logic              q5_zero_reg, q6_zero_reg;

    logic [63:0]        q2_s, q2_sll, q2_cross, q2_fh;
    logic signed [48:0] q2_fl;
    logic [63:0]        q2_sll_reg;
    logic [30:0]        q2_cross_reg;
    logic [48:0]        q2_fl_reg;
    logic [31:0]        q2_fh_reg;
    logic [39:0]        q2_q_reg;

    assign q2_s     = {{13{q1_q_reg[63]}}, q1_q_reg[63:13]};
    assign q2_sll   = q2_s[31:0] * q2_s[31:0];
    assign q2_cross = q2_s[31:0] * q2_s[63:32];
    assign q2_fl    = $signed({1'b0, q1_q_reg[31:0]}) * p8;
    assign q2_fh    = q1_q_reg[63:32] * {{16{p8[15]}}, p8};

    logic [63:0] q3_ss, q3_f;
    logic [63:0] q3_ss_reg;
    logic [39:0] q3_f40_reg, q3_q_reg;

    assign q3_ss = q2_sll_reg + {q2_cross_reg, 33'd0};
    assign q3_f  = {{15{q2_fl_reg[48]}}, q2_fl_reg} + {q2_fh_reg, 32'd0};

    logic signed [48:0] q4_el;
    logic [63:0]        q4_eh;
    logic [48:0]        q4_el_reg;
    logic [31:0]        q4_eh_reg;
    logic [39:0]        q4_f40_reg, q4_q_reg;

    assign q4_el = $signed({1'b0, q3_ss_reg[31:0]}) * p9;
    assign q4_eh = q3_ss_reg[63:32] * {{16{p9[15]}}, p9};

    logic [63:0] q5_e64;
    logic [39:0] q5_e40_reg, q5_f40_reg, q5_q_reg;

    assign q5_e64 = {{15{q4_el_reg[48]}}, q4_el_reg} + {q4_eh_reg, 32'd0};

    logic [39:0] q6_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q1_v_reg <= 1'b0;
            q2_v_reg <= 1'b0;
            q3_v_reg <= 1'b0;
            q4_v_reg <= 1'b0;
            q5_v_reg <= 1'b0;
            q6_v_reg <= 1'b0;
        end else if (adv) begin
            q1_v_reg <= dv_valid;
            q2_v_reg <= q1_v_reg;
            q3_v_reg <= q2_v_reg;
            q4_v_reg <= q3_v_reg;
            q5_v_reg <= q4_v_reg;
            q6_v_reg <= q5_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q1_q_reg     <= dv_side.qneg ? 64'd0 - dv_quo : dv_quo;
            q1_temp_reg  <= dv_side.temp;
            q1_zero_reg  <= dv_side.zero;

            q2_sll_reg   <= q2_sll;
            q2_cross_reg <= q2_cross[30:0];
            q2_fl_reg    <= q2_fl;
            q2_fh_reg    <= q2_fh[31:0];
            q2_q_reg     <= q1_q_reg[39:0];
            q2_temp_reg  <= q1_temp_reg;
            q2_zero_reg  <= q1_zero_reg;

            q3_ss_reg    <= q3_ss;
            q3_f40_reg   <= q3_f[58:19];
            q3_q_reg     <= q2_q_reg;
            q3_temp_reg  <= q2_temp_reg;
            q3_zero_reg  <= q2_zero_reg;

            q4_el_reg    <= q4_el;
            q4_eh_reg    <= q4_eh[31:0];
            q4_f40_reg   <= q3_f40_reg;
            q4_q_reg     <= q3_q_reg;
            q4_temp_reg  <= q3_temp_reg;
            q4_zero_reg  <= q3_zero_reg;

            q5_e40_reg   <= {q5_e64[63], q5_e64[63:25]};
            q5_f40_reg   <= q4_f40_reg;
            q5_q_reg     <= q4_q_reg;
            q5_temp_reg  <= q4_temp_reg;
            q5_zero_reg  <= q4_zero_reg;

            q6_sum_reg   <= q5_q_reg + q5_e40_reg + q5_f40_reg;
            q6_temp_reg  <= q5_temp_reg;
            q6_zero_reg  <= q5_zero_reg;
        end
    end

    // ---------------- result, output register and skid
    logic [31:0]        fin;
    logic [PRESS_W-1:0] fin_press;

    assign fin       = q6_sum_reg[39:8] + {{12{p7[15]}}, p7, 4'd0};
    assign fin_press = q6_zero_reg ? '0 : fin[31:8];

    logic               m_valid_reg, m_valid_next;
    logic               sk_valid_reg, sk_valid_next;
    logic [TEMP_W-1:0]  m_temp_reg, sk_temp_reg;
    logic [PRESS_W-1:0] m_press_reg, sk_press_reg;
    logic               m_pv_reg, sk_pv_reg;
    logic               out_free, load_from_skid, load_from_pipe, load_skid;

    assign adv            = !sk_valid_reg;
    assign s_ready        = adv;
    assign out_free       = !m_valid_reg || m_ready;
    assign load_from_skid = out_free && sk_valid_reg;
    assign load_from_pipe = out_free && adv;
    assign load_skid      = !out_free && adv && q6_v_reg;

    always_comb begin
        m_valid_next  = m_valid_reg;
        sk_valid_next = sk_valid_reg;
        if (load_from_skid) begin
            m_valid_next  = 1'b1;
            sk_valid_next = 1'b0;
        end else if (load_from_pipe) begin
            m_valid_next  = q6_v_reg;
        end else if (load_skid) begin
            sk_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            sk_valid_reg <= 1'b0;
        end else begin
            m_valid_reg  <= m_valid_next;
            sk_valid_reg <= sk_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_from_skid) begin
            m_temp_reg  <= sk_temp_reg;
            m_press_reg <= sk_press_reg;
            m_pv_reg    <= sk_pv_reg;
        end else if (load_from_pipe) begin
            m_temp_reg  <= q6_temp_reg;
            m_press_reg <= fin_press;
            m_pv_reg    <= !q6_zero_reg;
        end
        if (load_skid) begin
            sk_temp_reg  <= q6_temp_reg;
            sk_press_reg <= fin_press;
            sk_pv_reg    <= !q6_zero_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_temperature_centi = {{(TEMP_OUT_W-TEMP_W){m_temp_reg[TEMP_W-1]}}, m_temp_reg};
    assign m_pressure_pa       = m_press_reg;
    assign m_pressure_valid    = m_pv_reg;

endmodule

`default_nettype wire

/* rtl/core/btpc_chk.sv */
// Port-level checker for the compensation top level, with its bind.
// Depends on btpc_pkg and baro_temp_pressure_compensation_top.
`default_nettype none

module btpc_chk (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_ready,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [btpc_pkg::TEMP_OUT_W-1:0] m_temperature_centi,
    input  logic [btpc_pkg::PRESS_W-1:0]      m_pressure_pa,
    input  logic                              m_pressure_valid
);
    import btpc_pkg::*;

    // result beat held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_temperature_centi))
        else $error("result beat dropped or changed under stall");

    a_out_hold_press: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_pressure_pa) && $stable(m_pressure_valid))
        else $error("pressure changed under stall");

    // zero divisor gives zero pressure
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_pressure_valid |-> m_pressure_pa == '0)
        else $error("invalid pressure not zero");

    // input only backs up behind a stalled result
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && $past(m_valid && !m_ready))
        else $error("input stalled without output stall");

endmodule

bind baro_temp_pressure_compensation_top btpc_chk u_chk (.*);

`default_nettype wire

/* verif/btpc_result_checker.sv */
// Result checker for the barometric compensation block: snoops the input, result
// and register-write channels, predicts each result and compares it field by field.
// Depends on btpc_pkg.
`timescale 1ns / 100ps

module btpc_result_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic [btpc_pkg::RAW_W-1:0]        s_raw_temperature,
    input  logic [btpc_pkg::RAW_W-1:0]        s_raw_pressure,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [btpc_pkg::TEMP_OUT_W-1:0] m_temperature_centi,
    input  logic [btpc_pkg::PRESS_W-1:0]      m_pressure_pa,
    input  logic                              m_pressure_valid,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [btpc_pkg::CFG_W-1:0]        cfg_data,
    output int                                fail_count,
    output int                                pending
);
    import btpc_pkg::*;

    typedef struct packed {
        logic signed [TEMP_OUT_W-1:0] temp;
        logic [PRESS_W-1:0]           press;
        logic                         pvalid;
    } comp_result_t;

    logic [CFG_W-1:0] cal_word [4];
    comp_result_t     comp_expect_q [$];

    function automatic longint s16(input logic [CFG_W-1:0] w, input int pos);
        logic signed [15:0] f;
        f = w[pos +: 16];
        return longint'(f);
    endfunction

    function automatic longint asr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic comp_result_t compensate(input logic [RAW_W-1:0] rt,
                                                input logic [RAW_W-1:0] rp);
        comp_result_t r;
        int t1, t2, t3, a, d, b, fine, tmp;
        longint p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint x, y, den, num, p, e, f;
        t1 = int'({16'd0, cal_word[REG_TEMP_CAL][15:0]});
        t2 = int'(s16(cal_word[REG_TEMP_CAL], 16));
        t3 = int'(s16(cal_word[REG_TEMP_CAL], 32));
        p1 = longint'({48'd0, cal_word[REG_PRESS_A][15:0]});
        p2 = s16(cal_word[REG_PRESS_A], 16);
        p3 = s16(cal_word[REG_PRESS_A], 32);
        p4 = s16(cal_word[REG_PRESS_B], 0);
        p5 = s16(cal_word[REG_PRESS_B], 16);
        p6 = s16(cal_word[REG_PRESS_B], 32);
        p7 = s16(cal_word[REG_PRESS_C], 0);
        p8 = s16(cal_word[REG_PRESS_C], 16);
        p9 = s16(cal_word[REG_PRESS_C], 32);

        a = ((int'({12'd0, rt}) >>> 3) - (t1 <<< 1)) * t2;
        a = a >>> 11;
        d = (int'({12'd0, rt}) >>> 4) - t1;
        b = (d * d) >>> 12;
        b = (b * t3) >>> 14;
        fine = a + b;
        tmp = (fine * 5 + 128) >>> 8;
        r.temp = tmp;

        x = longint'(fine) - 64'sd128000;
        y = x * x * p6;
        y = y + ((x * p5) <<< 17);
        y = y + (p4 <<< 35);
        den = asr(x * x * p3, 8) + ((x * p2) <<< 12);
        den = asr(((64'sd1 <<< 47) + den) * p1, 33);

        r.press = '0;
        r.pvalid = 1'b0;
        if (den != 0) begin
            p = 64'sd1048576 - longint'({44'd0, rp});
            num = ((p <<< 31) - y) * 64'sd3125;
            if (den == -64'sd1) begin
                p = -num;
            end else begin
                p = num / den;
            end
            e = asr(p9 * asr(p, 13) * asr(p, 13), 25);
            f = asr(p8 * p, 19);
            p = asr(p + e + f, 8) + (p7 <<< 4);
            r.press = p[31:8];
            r.pvalid = 1'b1;
        end
        return r;
    endfunction

    always @(posedge aclk) begin : snoop
        comp_result_t want;
        int errs;
        errs = 0;
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) cal_word[i] <= '0;
            comp_expect_q.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) cal_word[cfg_index] <= cfg_data;
            if (s_valid && s_ready)
                comp_expect_q.push_back(compensate(s_raw_temperature, s_raw_pressure));
            if (m_valid && m_ready) begin
                if (comp_expect_q.size() == 0) begin
                    $display("%0t unexpected result beat: temp %0d press %0d valid %0b",
                             $time, m_temperature_centi, m_pressure_pa, m_pressure_valid);
                    errs = errs + 1;
                end else begin
                    want = comp_expect_q.pop_front();
                    if (want.temp !== m_temperature_centi) begin
                        $display("%0t temperature_centi: expected %0d actual %0d",
                                 $time, want.temp, m_temperature_centi);
                        errs = errs + 1;
                    end
                    if (want.press !== m_pressure_pa) begin
                        $display("%0t pressure_pa: expected %0d actual %0d",
                                 $time, want.press, m_pressure_pa);
                        errs = errs + 1;
                    end
                    if (want.pvalid !== m_pressure_valid) begin
                        $display("%0t pressure_valid: expected %0b actual %0b",
                                 $time, want.pvalid, m_pressure_valid);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending <= comp_expect_q.size();
        end
    end

endmodule

/* verif/tb_baro_temp_pressure_compensation_top.sv */
// Testbench top for baro_temp_pressure_compensation_top: clock, reset, calibration
// writes, bursty reading stimulus, receiver stalls and the verdict.
// Depends on btpc_pkg, the block RTL and btpc_result_checker.
`timescale 1ns / 100ps

module tb_baro_temp_pressure_compensation_top;
    import btpc_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int LONG_HOLD  = 300;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [RAW_W-1:0]          s_raw_temperature = '0;
    logic [RAW_W-1:0]          s_raw_pressure = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [TEMP_OUT_W-1:0] m_temperature_centi;
    logic [PRESS_W-1:0]        m_pressure_pa;
    logic                      m_pressure_valid;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;
    int                        fail_count;
    int                        pending;
    logic                      hold_req = 1'b0;
    int                        hold_left = 0;
    logic                      hold_done = 1'b0;
    int                        run_left = 0;
    logic                      run_stall = 1'b0;
    int                        run_pct = 100;
    int                        idle_cycles = 0;

    always #1 aclk = ~aclk;

    baro_temp_pressure_compensation_top u_top (
        .aclk, .aresetn, .s_valid, .s_ready, .s_raw_temperature, .s_raw_pressure,
        .m_valid, .m_ready, .m_temperature_centi, .m_pressure_pa, .m_pressure_valid,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
    );

    btpc_result_checker u_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_raw_temperature, .s_raw_pressure,
        .m_valid, .m_ready, .m_temperature_centi, .m_pressure_pa, .m_pressure_valid,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .fail_count, .pending
    );

    // receiver: random runs of ready-percentage, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            if (run_left == 0) begin
                run_left <= $urandom_range(5, 60);
                run_pct <= ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(10, 90);
            end else begin
                run_left <= run_left - 1;
            end
            m_ready <= ($urandom_range(1, 100) <= run_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t watchdog: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        logic took;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do begin
            @(negedge aclk);
            took = cfg_ready;
            @(posedge aclk);
        end while (!took);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_cal_set(input logic [CFG_W-1:0] t, input logic [CFG_W-1:0] a,
                                 input logic [CFG_W-1:0] b, input logic [CFG_W-1:0] c);
        write_cal(REG_TEMP_CAL, t);
        write_cal(REG_PRESS_A, a);
        write_cal(REG_PRESS_B, b);
        write_cal(REG_PRESS_C, c);
    endtask

    task automatic send_reading(input logic [RAW_W-1:0] rt, input logic [RAW_W-1:0] rp);
        logic took;
        s_valid <= 1'b1;
        s_raw_temperature <= rt;
        s_raw_pressure <= rp;
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
    endtask

    function automatic logic [CFG_W-1:0] rand_cal();
        logic [CFG_W-1:0] w;
        w = CFG_W'({$urandom, $urandom});
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
                0: w[16*k +: 16] = 16'h0000;
                1: w[16*k +: 16] = 16'hFFFF;
                2: w[16*k +: 16] = 16'h7FFF;
                3: w[16*k +: 16] = 16'h8000;
                default: ;
            endcase
        end
        return w;
    endfunction

    function automatic logic [RAW_W-1:0] rand_raw(input logic [RAW_W-1:0] center);
        case ($urandom_range(0, 3))
            0: return 20'($urandom);
            1: return ($urandom_range(0, 1)) ? 20'hFFFFF - 20'($urandom_range(0, 15))
                                              : 20'(($urandom_range(0, 15)));
            default: return center + 20'($urandom_range(0, 131071)) - 20'd65536;
        endcase
    endfunction

    task automatic send_random(input int n, input logic [RAW_W-1:0] tc,
                               input logic [RAW_W-1:0] pc, input logic do_hold);
        int burst;
        int i;
        burst = 0;
        i = 0;
        while (i < n) begin
            if (burst == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
            end
            if (do_hold && i == n / 3) hold_req <= 1'b1;
            send_reading(rand_raw(tc), rand_raw(pc));
            burst--;
            i++;
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // registers still at reset: zero divisor everywhere
        send_reading(20'h00000, 20'h00000);
        send_reading(20'hFFFFF, 20'hFFFFF);
        s_valid <= 1'b0;

        // typical calibration words
        write_cal_set({16'hFC18, 16'd26435, 16'd27504}, {16'd3024, 16'hD643, 16'd36477},
                      {16'hFFF9, 16'd140, 16'd2855}, {16'd6000, 16'hC6F8, 16'd15500});
        send_reading(20'd519888, 20'd415148);
        send_reading(20'h00000, 20'h00000);
        send_reading(20'hFFFFF, 20'hFFFFF);
        send_reading(20'h00000, 20'hFFFFF);
        send_reading(20'hFFFFF, 20'h00000);
        send_reading(20'h80000, 20'h7FFFF);
        s_valid <= 1'b0;
        send_random(160, 20'd519888, 20'd415148, 1'b1);

        // P1 = 0 forces a zero divisor with nonzero temperature words
        write_cal(REG_PRESS_A, {16'd3024, 16'hD643, 16'd0});
        send_reading(20'd519888, 20'd415148);
        send_reading(20'hFFFFF, 20'h00000);
        s_valid <= 1'b0;

        write_cal_set('1, '1, '1, '1);
        send_reading(20'h00000, 20'h00000);
        send_reading(20'hFFFFF, 20'hFFFFF);
        s_valid <= 1'b0;
        send_random(150, 20'h80000, 20'h80000, 1'b0);

        write_cal_set({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        send_random(150, 20'h80000, 20'h80000, 1'b0);

        write_cal_set({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        send_random(150, 20'h80000, 20'h80000, 1'b0);

        write_cal_set('0, '0, '0, '0);
        send_random(40, 20'h80000, 20'h80000, 1'b0);

        for (int ph = 0; ph < 7; ph++) begin
            write_cal_set(rand_cal(), rand_cal(), rand_cal(), rand_cal());
            send_random(150, 20'($urandom), 20'($urandom), 1'b0);
        end

        wait_drained();
        repeat (100) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
